// ===== hw/rtl/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg: shared types and constants for the byte pattern patch block
// Sizes, register indexes, result layout and the control groups passed
// between the window cells, the result queue and the top level.
// ----------------------------------------------------------------------------
package bpp_pkg;

  // Pattern window and offset sizes
  localparam int PATTERN_MAX    = 16;
  localparam int OFFSET_BITS    = 32;
  localparam int BYTE_W         = 8;
  localparam int CFG_W          = 64;
  localparam int LEN_W          = 5;
  localparam int IDX_W          = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int MATCH_OFFSET_W = 32;
  localparam int CFG_INDEX_W    = 3;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef logic [BYTE_W-1:0]         byte_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [OFFSET_BITS-1:0]    offset_t;
  typedef logic [63:0]               wide_t;
  typedef logic [MATCH_OFFSET_W-1:0] match_offset_t;
  typedef logic [FIFO_PTR_W-1:0]     fifo_ptr_t;
  typedef logic [FIFO_CNT_W-1:0]     fifo_cnt_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW        = 3'd0,
    REG_PATTERN_HIGH       = 3'd1,
    REG_REPLACEMENT_LOW    = 3'd2,
    REG_REPLACEMENT_HIGH   = 3'd3,
    REG_PATTERN_LENGTH     = 3'd4,
    REG_REPLACEMENT_LENGTH = 3'd5
  } cfg_reg_t;

  // Result kinds
  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_MATCH = 1'b1
  } kind_t;

  // One result as it sits in the output queue
  typedef struct packed {
    kind_t         kind;
    byte_t         out_byte;
    match_offset_t match_offset;
    logic          out_last;
  } result_t;

  // Per-cell control from the window sequencer
  typedef struct packed {
    logic shift;     // take the neighbor's byte
    logic load;      // take the incoming stream byte
    logic in_span;   // cell lies in the compared span
    logic keep_rep;  // replacement byte applies here, else zero
  } cell_ctrl_t;

  // Queue write requests: slot a first, slot b only together with a
  typedef struct packed {
    logic push_a;
    logic push_b;
  } fifo_push_t;

  // Queue free space
  typedef struct packed {
    logic one_free;
    logic two_free;
  } fifo_room_t;

endpackage

// ===== hw/rtl/byte_pattern_patch_top.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_patch_top: streaming find and replace of a byte pattern
// Finds leftmost non-overlapping hits of a 1 to 16 byte pattern, patches them
// in place and reports each hit with its stream offset.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle. Each byte enters a row of 16
// window cells; once the pattern length of bytes is held, the oldest byte
// leaves per input byte, so data lags the input by the pattern length. All
// cells compare against the pattern in the same cycle the byte arrives. A hit
// adds one report result, which occupies one extra output transfer; the input
// stalls when the four-entry result queue cannot take two results. On a byte
// marked last, the held bytes (up to the pattern length, more after a length
// change) drain from the cell row one per cycle while the queue has room;
// input stalls until the drain ends; configuration writes are always taken.
// ----------------------------------------------------------------------------
module byte_pattern_patch_top (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bpp_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               in_last,
  // result stream
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [bpp_pkg::BYTE_W-1:0]         out_byte,
  output logic [bpp_pkg::MATCH_OFFSET_W-1:0] match_offset,
  output logic                               out_last,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bpp_pkg::CFG_W-1:0]          cfg_data
);

  // Configuration registers
  logic [bpp_pkg::CFG_W-1:0] pattern_low;
  logic [bpp_pkg::CFG_W-1:0] pattern_high;
  logic [bpp_pkg::CFG_W-1:0] replacement_low;
  logic [bpp_pkg::CFG_W-1:0] replacement_high;
  bpp_pkg::len_t             pattern_length;
  bpp_pkg::len_t             replacement_length;

  // Window control state
  bpp_pkg::len_t   fill;
  bpp_pkg::len_t   skip;
  bpp_pkg::offset_t position;
  logic            flushing;

  // Working signals
  bpp_pkg::len_t   len;
  bpp_pkg::len_t   len_m1;
  bpp_pkg::len_t   rlen;
  bpp_pkg::len_t   fill1;
  bpp_pkg::len_t   fill2;
  bpp_pkg::len_t   base;
  logic            step;
  logic            emit;
  logic            check;
  logic            hit;
  logic            flush_pop;
  bpp_pkg::offset_t hit_offset;
  bpp_pkg::wide_t  hit_offset_wide;

  logic [2*bpp_pkg::CFG_W-1:0] pat_all;
  logic [2*bpp_pkg::CFG_W-1:0] rep_all;
  bpp_pkg::byte_t pat_b [bpp_pkg::PATTERN_MAX];
  bpp_pkg::byte_t rep_b [bpp_pkg::PATTERN_MAX];

  bpp_pkg::byte_t      held  [bpp_pkg::PATTERN_MAX];
  bpp_pkg::byte_t      nbr   [bpp_pkg::PATTERN_MAX];
  bpp_pkg::cell_ctrl_t ctrl  [bpp_pkg::PATTERN_MAX];
  bpp_pkg::byte_t      pat_s [bpp_pkg::PATTERN_MAX];
  bpp_pkg::byte_t      rep_s [bpp_pkg::PATTERN_MAX];
  logic [bpp_pkg::PATTERN_MAX-1:0] match;

  bpp_pkg::fifo_push_t push;
  bpp_pkg::fifo_room_t room;
  bpp_pkg::result_t    data_a;
  bpp_pkg::result_t    data_b;
  bpp_pkg::result_t    data_res;
  bpp_pkg::result_t    report_res;
  bpp_pkg::result_t    flush_res;
  bpp_pkg::result_t    head;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low        <= '0;
      pattern_high       <= '0;
      replacement_low    <= '0;
      replacement_high   <= '0;
      pattern_length     <= bpp_pkg::len_t'(1);
      replacement_length <= '0;
    end else if (cfg_valid) begin
      unique case (bpp_pkg::cfg_reg_t'(cfg_index))
        bpp_pkg::REG_PATTERN_LOW:        pattern_low      <= cfg_data;
        bpp_pkg::REG_PATTERN_HIGH:       pattern_high     <= cfg_data;
        bpp_pkg::REG_REPLACEMENT_LOW:    replacement_low  <= cfg_data;
        bpp_pkg::REG_REPLACEMENT_HIGH:   replacement_high <= cfg_data;
        bpp_pkg::REG_PATTERN_LENGTH:     pattern_length   <= cfg_data[bpp_pkg::LEN_W-1:0];
        bpp_pkg::REG_REPLACEMENT_LENGTH: begin
          replacement_length <= cfg_data[bpp_pkg::LEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Clamp lengths into the usable range
  always_comb begin
    if (pattern_length == '0) begin
      len = bpp_pkg::len_t'(1);
    end else if (pattern_length > bpp_pkg::len_t'(bpp_pkg::PATTERN_MAX)) begin
      len = bpp_pkg::len_t'(bpp_pkg::PATTERN_MAX);
    end else begin
      len = pattern_length;
    end
    rlen = (replacement_length > len) ? len : replacement_length;
  end

  assign len_m1 = bpp_pkg::len_t'(len - 1'b1);

  // Split pattern and replacement into bytes
  assign pat_all = {pattern_high, pattern_low};
  assign rep_all = {replacement_high, replacement_low};

  // Step bookkeeping
  assign in_stall  = flushing || !room.two_free;
  assign step      = in_valid && !in_stall;
  assign emit      = step && (fill >= len);
  assign fill1     = bpp_pkg::len_t'(fill - bpp_pkg::len_t'(emit));
  assign fill2     = bpp_pkg::len_t'(fill1 + 1'b1);
  assign check     = step && (fill2 >= len) && (skip == '0);
  assign base      = bpp_pkg::len_t'(fill2 - len);
  assign hit       = check && (&match);
  assign flush_pop = flushing && room.one_free;

  // Cell row
  for (genvar k = 0; k < bpp_pkg::PATTERN_MAX; k++) begin : g_cell
    bpp_pkg::len_t kk;
    bpp_pkg::idx_t j;

    assign kk = bpp_pkg::len_t'(k);
    assign j  = bpp_pkg::idx_t'(kk - base);

    assign pat_b[k] = pat_all[k*bpp_pkg::BYTE_W +: bpp_pkg::BYTE_W];
    assign rep_b[k] = rep_all[k*bpp_pkg::BYTE_W +: bpp_pkg::BYTE_W];

    if (k == bpp_pkg::PATTERN_MAX - 1) begin : g_end
      assign nbr[k] = '0;
    end else begin : g_mid
      assign nbr[k] = held[k+1];
    end

    assign ctrl[k].shift    = emit || flush_pop;
    assign ctrl[k].load     = step && (fill1 == kk);
    assign ctrl[k].in_span  = check && (kk >= base) && (kk < fill2);
    assign ctrl[k].keep_rep = (bpp_pkg::len_t'(j) < rlen);
    assign pat_s[k]         = pat_b[j];
    assign rep_s[k]         = rep_b[j];

    bpp_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[k]),
      .next_byte (nbr[k]),
      .new_byte  (in_byte),
      .pat_byte  (pat_s[k]),
      .rep_byte  (rep_s[k]),
      .hit       (hit),
      .held      (held[k]),
      .match     (match[k])
    );
  end

  // Hit offset, widened then cut to the report width
  assign hit_offset      = bpp_pkg::offset_t'(position - bpp_pkg::offset_t'(len_m1));
  assign hit_offset_wide = bpp_pkg::wide_t'(hit_offset);

  // Build results
  always_comb begin
    data_res              = '0;
    data_res.kind         = bpp_pkg::KIND_DATA;
    data_res.out_byte     = held[0];

    report_res              = '0;
    report_res.kind         = bpp_pkg::KIND_MATCH;
    report_res.match_offset = hit_offset_wide[bpp_pkg::MATCH_OFFSET_W-1:0];

    flush_res          = '0;
    flush_res.kind     = bpp_pkg::KIND_DATA;
    flush_res.out_byte = held[0];
    flush_res.out_last = (fill == bpp_pkg::len_t'(1));
  end

  // Queue writes: data byte first, then the report
  always_comb begin
    push.push_a = flush_pop || emit || hit;
    push.push_b = emit && hit;
    data_b      = report_res;
    if (flushing) begin
      data_a = flush_res;
    end else if (emit) begin
      data_a = data_res;
    end else begin
      data_a = report_res;
    end
  end

  // Window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      skip     <= '0;
      position <= '0;
      flushing <= 1'b0;
    end else if (step) begin
      fill <= fill2;
      if (in_last) begin
        skip     <= '0;
        position <= '0;
        flushing <= 1'b1;
      end else begin
        position <= bpp_pkg::offset_t'(position + 1'b1);
        if (fill2 >= len) begin
          if (skip != '0) begin
            skip <= bpp_pkg::len_t'(skip - 1'b1);
          end else if (hit) begin
            skip <= len_m1;
          end
        end
      end
    end else if (flush_pop) begin
      fill <= bpp_pkg::len_t'(fill - 1'b1);
      if (fill == bpp_pkg::len_t'(1)) begin
        flushing <= 1'b0;
      end
    end
  end

  bpp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_a    (data_a),
    .data_b    (data_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind         = head.kind;
  assign out_byte     = head.out_byte;
  assign match_offset = head.match_offset;
  assign out_last     = head.out_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= bpp_pkg::len_t'(bpp_pkg::PATTERN_MAX))
    else $error("window fill above capacity");

  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (step && in_last) |=> (flushing && (fill != '0)))
    else $error("last byte did not start a drain");

  a_skip_load: assert property (@(posedge clk) disable iff (rst)
    (hit && !in_last) |=> (skip == $past(len_m1)))
    else $error("overlap skip not loaded after hit");

  a_no_compare_in_drain: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (!check && !emit))
    else $error("compare or emit while draining");

endmodule

// ===== hw/rtl/bpp_cell.sv =====
// ----------------------------------------------------------------------------
// bpp_cell: one byte cell of the pattern window
// Holds one window byte, shifts toward the oldest end, loads the stream
// byte, compares against its aligned pattern byte and applies the patch.
// ----------------------------------------------------------------------------
module bpp_cell (
  input  logic                clk,
  input  bpp_pkg::cell_ctrl_t ctrl,
  input  bpp_pkg::byte_t      next_byte,
  input  bpp_pkg::byte_t      new_byte,
  input  bpp_pkg::byte_t      pat_byte,
  input  bpp_pkg::byte_t      rep_byte,
  input  logic                hit,
  output bpp_pkg::byte_t      held,
  output logic                match
);

  bpp_pkg::byte_t staged;
  bpp_pkg::byte_t held_next;

  // Advance the chain, then drop in the new byte
  always_comb begin
    staged = held;
    if (ctrl.shift) begin
      staged = next_byte;
    end
    if (ctrl.load) begin
      staged = new_byte;
    end
  end

  // Compare against the aligned pattern byte
  assign match = !ctrl.in_span || (staged == pat_byte);

  // Patch the span on a hit
  always_comb begin
    held_next = staged;
    if (hit && ctrl.in_span) begin
      held_next = ctrl.keep_rep ? rep_byte : '0;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

endmodule

// ===== hw/rtl/bpp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bpp_out_fifo: result queue
// Small queue between the window and the output channel. Takes up to two
// results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module bpp_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  bpp_pkg::fifo_push_t push,
  input  bpp_pkg::result_t    data_a,
  input  bpp_pkg::result_t    data_b,
  output bpp_pkg::fifo_room_t room,
  output logic                out_valid,
  input  logic                out_stall,
  output bpp_pkg::result_t    head
);

  bpp_pkg::result_t   entries [bpp_pkg::FIFO_DEPTH];
  bpp_pkg::fifo_ptr_t wr_ptr;
  bpp_pkg::fifo_ptr_t rd_ptr;
  bpp_pkg::fifo_cnt_t count;
  bpp_pkg::fifo_cnt_t count_next;
  bpp_pkg::fifo_ptr_t wr_ptr_b;
  logic               pop;
  logic [1:0]         n_push;

  assign pop       = (count != '0) && !out_stall;
  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign n_push    = {1'b0, push.push_a} + {1'b0, push.push_b};
  assign wr_ptr_b  = bpp_pkg::fifo_ptr_t'(wr_ptr + 1'b1);

  assign room.one_free = (count < bpp_pkg::fifo_cnt_t'(bpp_pkg::FIFO_DEPTH));
  assign room.two_free = (count <= bpp_pkg::fifo_cnt_t'(bpp_pkg::FIFO_DEPTH - 2));

  assign count_next = bpp_pkg::fifo_cnt_t'(count + bpp_pkg::fifo_cnt_t'(n_push)
                                           - bpp_pkg::fifo_cnt_t'(pop));

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      entries[wr_ptr] <= data_a;
    end
    if (push.push_b) begin
      entries[wr_ptr_b] <= data_b;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= bpp_pkg::fifo_ptr_t'(wr_ptr + n_push);
      rd_ptr <= bpp_pkg::fifo_ptr_t'(rd_ptr + pop);
      count  <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bpp_pkg::fifo_cnt_t'(bpp_pkg::FIFO_DEPTH))
    else $error("result queue over depth");

  a_second_slot: assert property (@(posedge clk) disable iff (rst)
    push.push_b |-> (push.push_a && room.two_free))
    else $error("second result pushed without first or without room");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push_a |-> room.one_free)
    else $error("result pushed into full queue");

endmodule

// ===== tb/sv/tb_byte_pattern_patch_top.sv =====
// ----------------------------------------------------------------------------
// tb_byte_pattern_patch_top: self-checking bench for the byte pattern patch
// Drives byte buffers through the block under random input and output stalls,
// mirrors the find-and-replace behavior in a local model and compares every
// output transfer, field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_byte_pattern_patch_top;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 350;
  localparam int MAX_REPORTS   = 10;

  // Writes to these indexes must be ignored by the block
  localparam logic [bpp_pkg::CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [bpp_pkg::CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  // One output transfer as the bench sees it
  typedef struct packed {
    bpp_pkg::kind_t kind;
    logic [7:0]     data;
    logic [31:0]    offs;
    logic           fin;
  } patch_result_t;

  // Results typed in by hand for a directed byte; n of zero means predict
  typedef struct packed {
    logic [1:0]               n;
    patch_result_t [2:0]      r;
  } typed_note_t;

  // One directed row: either a register write or a stream byte
  typedef struct packed {
    logic                            is_cfg;
    logic [bpp_pkg::CFG_INDEX_W-1:0] idx;
    logic [63:0]                     val;
    logic [7:0]                      b;
    logic                            fin;
    typed_note_t                     note;
  } stim_row_t;

  localparam typed_note_t NO_NOTE = '0;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [bpp_pkg::BYTE_W-1:0]         in_byte = '0;
  logic                               in_last = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               kind;
  logic [bpp_pkg::BYTE_W-1:0]         out_byte;
  logic [bpp_pkg::MATCH_OFFSET_W-1:0] match_offset;
  logic                               out_last;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [bpp_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [bpp_pkg::CFG_W-1:0]          cfg_data = '0;

  // Mirror of the block: configuration
  logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [4:0]  pat_len_raw, rep_len_raw;

  // Mirror of the block: window state
  logic [7:0]  held [bpp_pkg::PATTERN_MAX];
  int          held_cnt;
  int          skip_cnt;
  logic [31:0] stream_pos;

  patch_result_t step_q[$];
  patch_result_t patched_q[$];
  typed_note_t   typed_q[$];
  stim_row_t     rows[$];

  int  cycles;
  int  mismatches;
  int  bytes_in, buffers_done, random_items, reg_writes;
  int  data_seen, hits_seen, holds_done;
  bit  hold_req;

  byte_pattern_patch_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .match_offset (match_offset),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic patch_result_t mk_result(input bpp_pkg::kind_t k, input logic [7:0] d,
                                              input logic [31:0] o, input logic f);
    patch_result_t r;
    r.kind = k;
    r.data = d;
    r.offs = o;
    r.fin  = f;
    return r;
  endfunction

  function automatic logic [7:0] cfg_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int i);
    logic [63:0] w;
    w = (i < 8) ? lo : hi;
    return w[8*(i%8) +: 8];
  endfunction

  // Pattern length in use: zero acts as one, anything above the window as full
  function automatic int eff_len();
    int l;
    l = pat_len_raw;
    if (l < 1) l = 1;
    if (l > bpp_pkg::PATTERN_MAX) l = bpp_pkg::PATTERN_MAX;
    return l;
  endfunction

  function automatic void apply_cfg(input logic [bpp_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [63:0] val);
    case (idx)
      bpp_pkg::REG_PATTERN_LOW:        pat_lo = val;
      bpp_pkg::REG_PATTERN_HIGH:       pat_hi = val;
      bpp_pkg::REG_REPLACEMENT_LOW:    rep_lo = val;
      bpp_pkg::REG_REPLACEMENT_HIGH:   rep_hi = val;
      bpp_pkg::REG_PATTERN_LENGTH:     pat_len_raw = val[4:0];
      bpp_pkg::REG_REPLACEMENT_LENGTH: rep_len_raw = val[4:0];
      default: ;
    endcase
  endfunction

  // Advance the window by one stream byte and collect the results it causes
  function automatic void patch_step(input logic [7:0] b, input logic fin);
    int len, rlen, base;
    bit hit;
    step_q.delete();
    len  = eff_len();
    rlen = rep_len_raw;
    if (rlen > len) rlen = len;
    // push out the oldest byte once a full pattern is held
    if (held_cnt >= len) begin
      step_q = {step_q, mk_result(bpp_pkg::KIND_DATA, held[0], '0, 1'b0)};
      for (int i = 0; i < bpp_pkg::PATTERN_MAX - 1; i++) held[i] = held[i+1];
      held[bpp_pkg::PATTERN_MAX-1] = '0;
      held_cnt--;
    end
    held[held_cnt] = b;
    held_cnt++;
    // compare the newest len bytes unless still inside the last hit
    if (held_cnt >= len) begin
      if (skip_cnt > 0) begin
        skip_cnt--;
      end else begin
        base = held_cnt - len;
        hit  = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (held[base+i] != cfg_byte(pat_lo, pat_hi, i)) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < len; i++) begin
            held[base+i] = (i < rlen) ? cfg_byte(rep_lo, rep_hi, i) : 8'h00;
          end
          step_q = {step_q, mk_result(bpp_pkg::KIND_MATCH, 8'h00,
                                      stream_pos - 32'(len - 1), 1'b0)};
          skip_cnt = len - 1;
        end
      end
    end
    stream_pos++;
    // flush the held bytes and start a new buffer
    if (fin) begin
      for (int i = 0; i < held_cnt; i++)
        step_q = {step_q, mk_result(bpp_pkg::KIND_DATA, held[i], '0, 1'b0)};
      step_q[step_q.size()-1].fin = 1'b1;
      foreach (held[i]) held[i] = '0;
      held_cnt   = 0;
      skip_cnt   = 0;
      stream_pos = '0;
    end
  endfunction

  function automatic void add_cfg(input logic [bpp_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [63:0] val);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    rows = {rows, row};
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic fin);
    stim_row_t row;
    row     = '0;
    row.b   = b;
    row.fin = fin;
    rows = {rows, row};
  endfunction

  // Attach a hand-written result to the newest directed byte
  function automatic void expect_typed(input bpp_pkg::kind_t k, input logic [7:0] d,
                                       input logic [31:0] o, input logic f);
    int last_row;
    last_row = rows.size() - 1;
    rows[last_row].note.r[rows[last_row].note.n] = mk_result(k, d, o, f);
    rows[last_row].note.n = rows[last_row].note.n + 2'd1;
  endfunction

  function automatic logic [4:0] pick_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return 5'd1;
    if (roll < 40) return 5'd16;
    if (roll < 48) return 5'd0;
    if (roll < 58) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(15, 2));
  endfunction

  // Length words sometimes carry junk above the five used bits
  function automatic logic [63:0] with_noise(input logic [4:0] v);
    logic [63:0] w;
    w = '0;
    if ($urandom_range(9) < 3) w = {$urandom, $urandom};
    w[4:0] = v;
    return w;
  endfunction

  // Offer one stream byte after a random gap and hold it until the transfer
  task automatic offer_byte(input logic [7:0] b, input logic fin, input typed_note_t note);
    int roll, gap;
    roll = $urandom_range(99);
    gap  = (roll < 70) ? 0 : (roll < 94) ? $urandom_range(3, 1) : $urandom_range(25, 10);
    typed_q = {typed_q, note};
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every predicted result, then let the cell row drain
  task automatic settle();
    in_valid <= 1'b0;
    while (patched_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  // Build a buffer rich in full and partial hits, optionally changing length midway
  task automatic send_buffer(input int n_bytes, input bit relen);
    logic [7:0] content[$];
    int len, pick, cut, split;
    len = eff_len();
    while (content.size() < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        for (int k = 0; k < len; k++) content = {content, cfg_byte(pat_lo, pat_hi, k)};
      end else if (pick < 50 && len > 1) begin
        cut = $urandom_range(len - 1, 1);
        for (int k = 0; k < cut; k++) content = {content, cfg_byte(pat_lo, pat_hi, k)};
      end else if (pick < 75) begin
        content = {content, cfg_byte(pat_lo, pat_hi, $urandom_range(len - 1))};
      end else begin
        content = {content, 8'($urandom_range(255))};
      end
    end
    split = (relen && content.size() > 1) ? $urandom_range(content.size() - 1, 1) : -1;
    foreach (content[k]) begin
      if (k == split) begin
        settle();
        write_reg(bpp_pkg::REG_PATTERN_LENGTH, with_noise(pick_len()));
      end
      offer_byte(content[k], k == content.size() - 1, NO_NOTE);
      random_items++;
    end
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, patched_q.size());
      $display("byte_pattern_patch_top: mismatch");
      $finish;
    end
  end

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    typed_note_t   note;
    patch_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        note = typed_q.pop_front();
        patch_step(in_byte, in_last);
        bytes_in++;
        if (in_last) buffers_done++;
        if (note.n != 0) begin
          for (int i = 0; i < note.n; i++) patched_q = {patched_q, note.r[i]};
        end else begin
          patched_q = {patched_q, step_q};
        end
      end
      if (out_valid && !out_stall) begin
        if (patched_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: kind %0d byte %02h offset %0d last %0b",
                     kind, out_byte, match_offset, out_last);
        end else begin
          want = patched_q.pop_front();
          if (kind == bpp_pkg::KIND_MATCH) hits_seen++;
          else data_seen++;
          if (want.kind != kind || want.data != out_byte ||
              want.offs != match_offset || want.fin != out_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected kind %0d byte %02h offset %0d last %0b, %s",
                       want.kind, want.data, want.offs, want.fin,
                       $sformatf("got kind %0d byte %02h offset %0d last %0b",
                                 kind, out_byte, match_offset, out_last));
          end
        end
      end
    end
  end

  // Stall the result side: mostly open runs, short stalls, a few long ones,
  // and one long hold-off on request
  initial begin
    int roll, span;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          out_stall <= 1'b0;
          span = $urandom_range(30, 1);
        end else if (roll < 90) begin
          out_stall <= 1'b1;
          span = $urandom_range(3, 1);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(24, 8);
        end
        repeat (span - 1) @(posedge clk);
      end
    end
  end

  initial begin
    logic [63:0] plo, phi;
    logic [7:0]  sym_a, sym_b, pb;
    logic [4:0]  plen, rlen;
    bit          prev_item;
    int          ph, n_buf;

    // Reset values of the mirror
    pat_lo = '0;
    pat_hi = '0;
    rep_lo = '0;
    rep_hi = '0;
    pat_len_raw = 5'd1;
    rep_len_raw = 5'd0;
    foreach (held[i]) held[i] = '0;
    held_cnt   = 0;
    skip_cnt   = 0;
    stream_pos = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // After reset: one-byte zero pattern, empty replacement
    add_byte(8'h00, 1'b0); expect_typed(bpp_pkg::KIND_MATCH, 8'h00, 32'd0, 1'b0);
    add_byte(8'hFF, 1'b1); expect_typed(bpp_pkg::KIND_DATA, 8'h00, 32'd0, 1'b0);
    expect_typed(bpp_pkg::KIND_DATA, 8'hFF, 32'd0, 1'b1);
    add_byte(8'hAA, 1'b1); expect_typed(bpp_pkg::KIND_DATA, 8'hAA, 32'd0, 1'b1);
    add_byte(8'h00, 1'b1); expect_typed(bpp_pkg::KIND_MATCH, 8'h00, 32'd0, 1'b0);
    expect_typed(bpp_pkg::KIND_DATA, 8'h00, 32'd0, 1'b1);
    // Spare indexes, all-ones upper halves, zero length, overlong replacement
    add_cfg(REG_SPARE_6, '1);
    add_cfg(REG_SPARE_7, '1);
    add_cfg(bpp_pkg::REG_PATTERN_HIGH, '1);
    add_cfg(bpp_pkg::REG_REPLACEMENT_HIGH, '1);
    add_cfg(bpp_pkg::REG_PATTERN_LOW, 64'h1122_3344_5566_7788);
    add_cfg(bpp_pkg::REG_REPLACEMENT_LOW, 64'h0000_0000_0000_00EE);
    add_cfg(bpp_pkg::REG_PATTERN_LENGTH, 64'd0);
    add_cfg(bpp_pkg::REG_REPLACEMENT_LENGTH, 64'd16);
    add_byte(8'h88, 1'b0); expect_typed(bpp_pkg::KIND_MATCH, 8'h00, 32'd0, 1'b0);
    add_byte(8'h88, 1'b1); expect_typed(bpp_pkg::KIND_DATA, 8'hEE, 32'd0, 1'b0);
    expect_typed(bpp_pkg::KIND_MATCH, 8'h00, 32'd1, 1'b0);
    expect_typed(bpp_pkg::KIND_DATA, 8'hEE, 32'd0, 1'b1);
    // Overlapping candidates: a run of one repeated byte
    add_cfg(bpp_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_AAAA);
    add_cfg(bpp_pkg::REG_REPLACEMENT_LOW, 64'h0000_0000_0000_005C);
    add_cfg(bpp_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_cfg(bpp_pkg::REG_REPLACEMENT_LENGTH, 64'd1);
    repeat (4) add_byte(8'hAA, 1'b0);
    add_byte(8'hAA, 1'b1);
    // Length shrinks in the middle of a buffer
    add_cfg(bpp_pkg::REG_PATTERN_LOW, 64'h0000_0000_0003_0201);
    add_cfg(bpp_pkg::REG_REPLACEMENT_LOW, 64'h0000_0000_00C3_C2C1);
    add_cfg(bpp_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_cfg(bpp_pkg::REG_REPLACEMENT_LENGTH, 64'd3);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_cfg(bpp_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_0302);
    add_cfg(bpp_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_byte(8'h03, 1'b0);
    add_byte(8'h04, 1'b1);
    // Length grows in the middle of a buffer
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_cfg(bpp_pkg::REG_PATTERN_LOW, 64'h0000_0000_0403_0201);
    add_cfg(bpp_pkg::REG_PATTERN_LENGTH, 64'd4);
    add_byte(8'h03, 1'b0);
    add_byte(8'h04, 1'b1);

    // Walk the directed table, settling before each group of writes
    prev_item = 1'b0;
    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        if (prev_item) settle();
        write_reg(rows[r].idx, rows[r].val);
        prev_item = 1'b0;
      end else begin
        offer_byte(rows[r].b, rows[r].fin, rows[r].note);
        prev_item = 1'b1;
      end
    end

    // Random phases: new settings, then a few hit-rich buffers; always reach
    // the phase with the long output hold-off
    ph = 0;
    while (random_items < RANDOM_ITEMS || ph < 4) begin
      settle();
      if ($urandom_range(1)) begin
        sym_a = 8'($urandom_range(255));
        sym_b = 8'($urandom_range(255));
        for (int k = 0; k < bpp_pkg::PATTERN_MAX; k++) begin
          pb = $urandom_range(1) ? sym_a : sym_b;
          if (k < 8) plo[8*k +: 8] = pb;
          else phi[8*(k-8) +: 8] = pb;
        end
      end else begin
        plo = {$urandom, $urandom};
        phi = {$urandom, $urandom};
      end
      plen = (ph == 0) ? 5'd16 : (ph == 1) ? 5'd20 : (ph == 2) ? 5'd1 : pick_len();
      rlen = (ph == 0) ? 5'd16 : (ph == 1) ? 5'd31 : (ph == 2) ? 5'd0 :
             5'($urandom_range(31));
      write_reg(bpp_pkg::REG_PATTERN_LOW, plo);
      write_reg(bpp_pkg::REG_PATTERN_HIGH, phi);
      write_reg(bpp_pkg::REG_REPLACEMENT_LOW, {$urandom, $urandom});
      write_reg(bpp_pkg::REG_REPLACEMENT_HIGH, {$urandom, $urandom});
      write_reg(bpp_pkg::REG_PATTERN_LENGTH, with_noise(plen));
      write_reg(bpp_pkg::REG_REPLACEMENT_LENGTH, with_noise(rlen));
      // hold the result side off while a long buffer keeps coming
      if (ph == 3) begin
        hold_req = 1'b1;
        send_buffer(48, 1'b0);
      end
      n_buf = $urandom_range(3, 1);
      for (int k = 0; k < n_buf; k++) begin
        if ($urandom_range(9) == 0) send_buffer(40, $urandom_range(99) < 15);
        else send_buffer(eff_len() * $urandom_range(3, 1) + $urandom_range(6),
                         $urandom_range(99) < 15);
      end
      ph++;
    end

    settle();
    $display("covered %0d bytes in %0d buffers (%0d random) over %0d settings, %0d reg writes",
             bytes_in, buffers_done, random_items, ph, reg_writes);
    $display("checked %0d data bytes and %0d hit reports, %0d long output hold-offs",
             data_seen, hits_seen, holds_done);
    if (mismatches == 0 && patched_q.size() == 0) begin
      $display("byte_pattern_patch_top: match");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, patched_q.size());
      $display("byte_pattern_patch_top: mismatch");
    end
    $finish;
  end

endmodule
